// File: hdl/pressure_temperature_compensation_top_macros.svh
// Assertion macros for the RTL top module.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PTC_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PTC_ASSERT(name, prop) `PTC_ASSERT_CLK(name, clk_i, rst_ni, prop)
`else
`define PTC_ASSERT_CLK(name, clk, rst_n, prop)
`define PTC_ASSERT(name, prop)
`endif

`endif

// File: hdl/ptc_pkg.sv
package ptc_pkg;

  localparam int unsigned CalWidth   = 16;
  localparam int unsigned RawWidth   = 24;
  localparam int unsigned TempWidth  = 19;
  localparam int unsigned PressWidth = 24;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 48;

  localparam int TempBase   = 2000;
  localparam int TempShift  = 23;
  localparam int OffShift   = 7;
  localparam int SensShift  = 8;
  localparam int ProdShift  = 21;
  localparam int PressShift = 13;
  localparam int SensLoBits = 17;

  typedef enum logic [CfgAddrWidth-1:0] {
    CfgPressSens    = 3'd0,
    CfgPressOffset  = 3'd1,
    CfgSensTempCo   = 3'd2,
    CfgOffTempCo    = 3'd3,
    CfgRefTemp      = 3'd4,
    CfgTempSens     = 3'd5
  } cfg_idx_e;

endpackage

// File: hdl/pressure_temperature_compensation_top.sv
// Pressure and temperature compensation, first order. Each item carries a raw
// pressure and a raw temperature conversion and yields one item with the
// compensated temperature (0.01 degC) and pressure (0.1 mbar). The datapath is
// an eight-stage pipeline: one item is taken every cycle unless the output
// stalls it; the depth is set by the 34 x 24 bit pressure product, done as two
// partial products, and the truncating shifts that follow. The user must write
// the six calibration words through the cfg port only while no item is in
// flight; the block itself does not enforce this.
`include "pressure_temperature_compensation_top_macros.svh"

module pressure_temperature_compensation_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ptc_pkg::CfgAddrWidth-1:0]     cfg_addr_i,
  input  logic [ptc_pkg::CalWidth-1:0]         cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [23:0] pressure_raw, [47:24] temperature_raw
  input  logic [ptc_pkg::InDataWidth-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [18:0] temperature_centi_c, [42:19] pressure_tenth_mbar, [47:43] zero
  output logic [ptc_pkg::OutDataWidth-1:0]     m_axis_tdata
);

  localparam int unsigned NumStages = 8;

  logic [ptc_pkg::CalWidth-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      case (ptc_pkg::cfg_idx_e'(cfg_addr_i))
        ptc_pkg::CfgPressSens:   c1_q <= cfg_wdata_i;
        ptc_pkg::CfgPressOffset: c2_q <= cfg_wdata_i;
        ptc_pkg::CfgSensTempCo:  c3_q <= cfg_wdata_i;
        ptc_pkg::CfgOffTempCo:   c4_q <= cfg_wdata_i;
        ptc_pkg::CfgRefTemp:     c5_q <= cfg_wdata_i;
        ptc_pkg::CfgTempSens:    c6_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [NumStages-1:0] valid_q, valid_d, en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NumStages-1];

  // stage 0: temperature difference
  logic [ptc_pkg::RawWidth-1:0] praw0_q, praw1_q, praw2_q;
  logic signed [24:0] dt0_d, dt0_q;

  assign dt0_d = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, c5_q, 8'd0});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      praw0_q <= s_axis_tdata[23:0];
      dt0_q   <= dt0_d;
    end
  end

  // stage 1: coefficient products
  logic signed [40:0] m6_d, m4_d, m3_d, m6_q, m4_q, m3_q;

  assign m6_d = dt0_q * $signed({1'b0, c6_q});
  assign m4_d = dt0_q * $signed({1'b0, c4_q});
  assign m3_d = dt0_q * $signed({1'b0, c3_q});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      praw1_q <= praw0_q;
      m6_q    <= m6_d;
      m4_q    <= m4_d;
      m3_q    <= m3_d;
    end
  end

  // stage 2: temperature, offset and sensitivity, truncated toward zero
  logic signed [40:0] t6, t4, t3;
  logic signed [ptc_pkg::TempWidth-1:0] temp2_d, temp2_q, temp3_q, temp4_q;
  logic signed [ptc_pkg::TempWidth-1:0] temp5_q, temp6_q, temp7_q;
  logic signed [34:0] off2_d, off2_q, off3_q, off4_q, off5_q;
  logic signed [33:0] sens2_d, sens2_q;

  assign t6 = m6_q + (m6_q[40] ? 41'(2 ** ptc_pkg::TempShift - 1) : '0);
  assign t4 = m4_q + (m4_q[40] ? 41'(2 ** ptc_pkg::OffShift - 1) : '0);
  assign t3 = m3_q + (m3_q[40] ? 41'(2 ** ptc_pkg::SensShift - 1) : '0);

  assign temp2_d = 19'(t6 >>> ptc_pkg::TempShift) + 19'(ptc_pkg::TempBase);
  assign off2_d  = $signed({3'd0, c2_q, 16'd0}) + 35'(t4 >>> ptc_pkg::OffShift);
  assign sens2_d = $signed({3'd0, c1_q, 15'd0}) + 34'(t3 >>> ptc_pkg::SensShift);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      praw2_q <= praw1_q;
      temp2_q <= temp2_d;
      off2_q  <= off2_d;
      sens2_q <= sens2_d;
    end
  end

  // stage 3: pressure partial products
  logic [40:0] pplo3_d, pplo3_q;
  logic signed [40:0] pphi3_d, pphi3_q;

  assign pplo3_d = praw2_q * sens2_q[ptc_pkg::SensLoBits-1:0];
  assign pphi3_d = $signed({1'b0, praw2_q}) * $signed(sens2_q[33:ptc_pkg::SensLoBits]);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pplo3_q <= pplo3_d;
      pphi3_q <= pphi3_d;
      temp3_q <= temp2_q;
      off3_q  <= off2_q;
    end
  end

  // stage 4: merge partial products
  logic signed [57:0] prod4_d, prod4_q;

  assign prod4_d = (58'(pphi3_q) <<< ptc_pkg::SensLoBits) + $signed({17'd0, pplo3_q});

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      prod4_q <= prod4_d;
      temp4_q <= temp3_q;
      off4_q  <= off3_q;
    end
  end

  // stage 5: scale product
  logic signed [57:0] tq;
  logic signed [36:0] quo5_d, quo5_q;

  assign tq     = prod4_q + (prod4_q[57] ? 58'(2 ** ptc_pkg::ProdShift - 1) : '0);
  assign quo5_d = 37'(tq >>> ptc_pkg::ProdShift);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      quo5_q  <= quo5_d;
      temp5_q <= temp4_q;
      off5_q  <= off4_q;
    end
  end

  // stage 6: remove offset
  logic signed [37:0] diff6_d, diff6_q;

  assign diff6_d = 38'(quo5_q) - 38'(off5_q);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      diff6_q <= diff6_d;
      temp6_q <= temp5_q;
    end
  end

  // stage 7: final scale, output register
  logic signed [37:0] tp;
  logic signed [ptc_pkg::PressWidth-1:0] press7_d, press7_q;

  assign tp       = diff6_q + (diff6_q[37] ? 38'(2 ** ptc_pkg::PressShift - 1) : '0);
  assign press7_d = 24'(tp >>> ptc_pkg::PressShift);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      press7_q <= press7_d;
      temp7_q  <= temp6_q;
    end
  end

  assign m_axis_tdata = {5'd0, press7_q, temp7_q};

  `PTC_ASSERT(a_full_when_stalled, !s_axis_tready |-> (&valid_q))
  `PTC_ASSERT(a_accept_fills_first, (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
  `PTC_ASSERT(a_drain_empties_out,
    (m_axis_tvalid && m_axis_tready && !valid_q[NumStages-2]) |=> !m_axis_tvalid)
  `PTC_ASSERT(a_temp_in_range,
    m_axis_tvalid |-> ((temp7_q >= -19'sd129070) && (temp7_q <= 19'sd133071)))

endmodule

// File: tb/sv/pressure_temperature_compensation_top_tb.sv
`timescale 1ns / 100ps

module pressure_temperature_compensation_top_tb;
  import ptc_pkg::*;

  localparam logic [CfgAddrWidth-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgAddrWidth-1:0] CfgSpare7 = 3'd7;
  localparam int NumCal        = 6;
  localparam int MaxGap        = 11;
  localparam int LongHold      = 150;
  localparam int HoldAtReading = 400;
  localparam int PhaseItems    = 180;
  localparam int Settle        = 16;
  localparam int CycleLimit    = 500000;
  localparam logic [RawWidth-1:0] RawMax = '1;
  localparam logic [CalWidth-1:0] CalMax = '1;

  typedef struct packed {
    logic [RawWidth-1:0] traw;
    logic [RawWidth-1:0] praw;
  } sample_t;

  typedef struct packed {
    logic signed [PressWidth-1:0] press;
    logic signed [TempWidth-1:0]  temp;
  } reading_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr_i = '0;
  logic [CalWidth-1:0]     cfg_wdata_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [23:0] pressure_raw, [47:24] temperature_raw
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [18:0] temperature_centi_c, [42:19] pressure_tenth_mbar, [47:43] zero
  logic [OutDataWidth-1:0] m_axis_tdata;

  bit [CalWidth-1:0] cal_words [NumCal];
  sample_t           sample_q [$];
  reading_t          reading_q [$];
  bit                sample_took;
  bit                quiet;
  bit                long_hold_done;
  int                src_gap;
  int                sink_hold;
  int                readings_seen;
  int                err_count;
  int                cycle_count;

  pressure_temperature_compensation_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic reading_t compensate(sample_t s);
    longint d_t;
    longint t_c;
    longint offs;
    longint sens;
    longint p;
    reading_t r;
    d_t  = longint'(s.traw) - longint'(cal_words[CfgRefTemp]) * 256;
    t_c  = TempBase + d_t * longint'(cal_words[CfgTempSens]) / 64'sd8388608;
    offs = longint'(cal_words[CfgPressOffset]) * 65536
         + longint'(cal_words[CfgOffTempCo]) * d_t / 128;
    sens = longint'(cal_words[CfgPressSens]) * 32768
         + longint'(cal_words[CfgSensTempCo]) * d_t / 256;
    p    = (longint'(s.praw) * sens / 64'sd2097152 - offs) / 8192;
    r.temp  = t_c[TempWidth-1:0];
    r.press = p[PressWidth-1:0];
    return r;
  endfunction

  function automatic logic [RawWidth-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RawMax;
      default: return RawWidth'($urandom);
    endcase
  endfunction

  // keep some temperatures near the reference so small negative deltas show up
  function automatic logic [RawWidth-1:0] pick_traw();
    int near;
    near = int'(cal_words[CfgRefTemp]) * 256 + int'($urandom_range(0, 1200)) - 600;
    if ($urandom_range(0, 3) == 0) return near[RawWidth-1:0];
    return pick_raw();
  endfunction

  task automatic add_sample(logic [RawWidth-1:0] praw, logic [RawWidth-1:0] traw);
    sample_t s;
    s.praw = praw;
    s.traw = traw;
    sample_q.push_back(s);
  endtask

  task automatic write_cal(logic [CfgAddrWidth-1:0] idx, logic [CalWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    if (idx <= CfgTempSens) cal_words[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cal(bit [CalWidth-1:0] w [NumCal]);
    for (int i = 0; i < NumCal; i++) write_cal(CfgAddrWidth'(i), w[i]);
  endtask

  task automatic drain();
    do @(negedge clk_i); while (sample_q.size() != 0 || reading_q.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (s_axis_tvalid && !sample_took) begin
      // hold the offered item
    end else if (src_gap > 0) begin
      src_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (sample_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      src_gap = $urandom_range(0, MaxGap - 1);
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= sample_q[0];
    end
  end

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && readings_seen >= HoldAtReading) begin
      long_hold_done = 1'b1;
      sink_hold = LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(0, MaxGap - 1);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check
    reading_t want;
    reading_t got;
    sample_took = s_axis_tvalid && s_axis_tready;
    if (sample_took) begin
      reading_q.push_back(compensate(s_axis_tdata));
      void'(sample_q.pop_front());
    end
    if (m_axis_tvalid && m_axis_tready) begin
      readings_seen++;
      got = m_axis_tdata[TempWidth+PressWidth-1:0];
      if (reading_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected item, expected none, got temp %0d press %0d",
                 $time, got.temp, got.press);
      end else begin
        want = reading_q.pop_front();
        if (got.temp !== want.temp) begin
          err_count++;
          $display("%0t: temperature mismatch, expected %0d, got %0d",
                   $time, want.temp, got.temp);
        end
        if (got.press !== want.press) begin
          err_count++;
          $display("%0t: pressure mismatch, expected %0d, got %0d",
                   $time, want.press, got.press);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("pressure_temperature_compensation_top_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    bit [CalWidth-1:0] words [NumCal];
    int ph;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_sample('0, '0);
    add_sample(RawMax, RawMax);
    add_sample(24'h123456, 24'h654321);
    drain();

    words = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
    load_cal(words);
    write_cal(CfgSpare6, CalWidth'($urandom));
    write_cal(CfgSpare7, CalWidth'($urandom));
    add_sample(24'd4311550, 24'd8387300);
    add_sample('0, '0);
    add_sample(RawMax, RawMax);
    add_sample(RawMax, '0);
    add_sample('0, RawMax);
    add_sample(24'h800000, 24'h800000);
    drain();

    words = '{CalMax, CalMax, CalMax, CalMax, CalMax, CalMax};
    load_cal(words);
    add_sample(RawMax, '0);
    add_sample(RawMax, RawMax);
    add_sample('0, '0);
    add_sample(RawMax, 24'hFFFF00);
    add_sample(RawMax, 24'hFFFEFF);
    drain();

    for (ph = 0; ph < 9; ph++) begin
      for (int i = 0; i < NumCal; i++) begin
        case (ph)
          0: words[i] = '0;
          1: words[i] = CalMax;
          6, 7: begin
            case ($urandom_range(0, 2))
              0: words[i] = '0;
              1: words[i] = CalMax;
              default: words[i] = CalWidth'($urandom);
            endcase
          end
          default: words[i] = CalWidth'($urandom);
        endcase
      end
      if (ph == 8) quiet = 1'b1;
      load_cal(words);
      repeat (PhaseItems) add_sample(pick_raw(), pick_traw());
      drain();
    end

    repeat (Settle) @(negedge clk_i);
    if (err_count == 0) begin
      $display("pressure_temperature_compensation_top_tb: done, clean");
    end else begin
      $display("pressure_temperature_compensation_top_tb: done, errors");
    end
    $finish;
  end

endmodule
